// ----- src/gbs_pkg.sv -----
`timescale 1ns / 1ps
package gbs_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_GLYPHS = 256;

   localparam int XW = $clog2(MAX_WIDTH) + 1;
   localparam int YW = $clog2(MAX_HEIGHT) + 1;
   localparam int GW = $clog2(MAX_GLYPHS) + 1;
   localparam int MAP_AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int GLY_AW = $clog2(MAX_GLYPHS);
   localparam int LIM_W = MAP_AW + 1;

   localparam logic [1:0] REG_MARKER = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;
   localparam logic [1:0] REG_TOTAL  = 2'd3;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_REF    = 3'd1;
   localparam logic [2:0] ST_UNTERM    = 3'd2;
   localparam logic [2:0] ST_MISSING   = 3'd3;
   localparam logic [2:0] ST_BAD_INDEX = 3'd4;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_STEP = 6'b000010,
      S_ADDR = 6'b000100,
      S_MEM  = 6'b001000,
      S_EVAL = 6'b010000,
      S_EMIT = 6'b100000
   } state_type;

   typedef enum logic [5:0] {
      P_FIND_REF    = 6'b000001,
      P_REF_DOWN    = 6'b000010,
      P_REF_RIGHT   = 6'b000100,
      P_COL_START   = 6'b001000,
      P_COL_SCAN    = 6'b010000,
      P_GLYPH_RIGHT = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [XW-1:0]   rx;
      logic [YW-1:0]   ry;
      logic [XW:0]     rw;
      logic [YW-1:0]   yoff;
   } glyph_type;

endpackage

// ----- src/glyph_box_scanner.sv -----
`timescale 1ns / 1ps
// Pixel write: one item per cycle when idle; result only on the sheet's last pixel.
// Scan after the last pixel: each marker-map lookup steps through address multiply,
// registered map read and evaluate on one shared lookup path; report follows.
// Glyph read: result is registered from the emit state; next request waits for idle.
// Synchronous active-high reset restores register defaults and clears counters;
// marker map and glyph table contents are not cleared.
module glyph_box_scanner
   import gbs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // pixel[31:0], glyph_index[39:32]
   input  logic         req_tuser,   // command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,   // status, found_count, row_height, ref_width,
                                     // rect_x, rect_y, rect_w, rect_h, y_offset, pad
   output logic         rsp_tuser,   // is_report
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   logic [31:0]     marker_ff;
   logic [10:0]     width_ff;
   logic [8:0]      height_cfg_ff;
   logic [8:0]      total_ff;

   state_type       state_ff, state_in;
   phase_type       phase_ff, phase_in;
   logic [MAP_AW-1:0] pc_ff, pc_in;
   logic [GW-1:0]   found_ff, found_in;
   logic [YW-1:0]   rowh_ff, rowh_in;
   logic [XW-1:0]   refw_ff, refw_in;
   logic            first_ff, first_in;
   logic [XW-1:0]   x_ff, x_in, xb_ff, xb_in;
   logic [YW:0]     y_ff, y_in;
   logic [YW-1:0]   yref_ff, yref_in, ytop_ff, ytop_in, yend_ff, yend_in;
   logic [2:0]      pend_status_ff, pend_status_in;
   logic            pend_rep_ff, pend_rep_in;
   logic            pend_rec_ff, pend_rec_in;
   logic [MAP_AW-1:0] addr_ff;

   logic            map_mem [MAX_WIDTH*MAX_HEIGHT];
   logic            map_q_ff;
   glyph_type       gly_mem [MAX_GLYPHS];
   glyph_type       gly_q_ff;

   logic            rsp_valid_ff;
   logic [87:0]     rsp_data_ff;
   logic [87:0]     rsp_data_in;
   logic            rsp_user_ff;

   logic [XW-1:0]   eff_w;
   logic [YW-1:0]   eff_h;
   logic [GW-1:0]   eff_total;
   logic [LIM_W-1:0] limit;
   logic [LIM_W-1:0] pc_next;
   logic            accept, map_we, gly_we;
   glyph_type       gly_wr;
   logic [XW-1:0]   rd_x;
   logic [YW-1:0]   rowh_new;
   logic signed [YW+1:0] ytop_calc;
   logic            emit_go;
   logic [31:0]     pixel;
   logic [7:0]      gidx;

   assign pixel = req_tdata[31:0];
   assign gidx  = req_tdata[39:32];

   always_comb begin
      eff_w = width_ff;
      if (width_ff < 11'd2) eff_w = 11'd2;
      else if (width_ff > 11'(MAX_WIDTH)) eff_w = 11'(MAX_WIDTH);
      eff_h = height_cfg_ff;
      if (height_cfg_ff < 9'd1) eff_h = 9'd1;
      else if (height_cfg_ff > 9'(MAX_HEIGHT)) eff_h = 9'(MAX_HEIGHT);
      eff_total = total_ff;
      if (total_ff < 9'd1) eff_total = 9'd1;
      else if (total_ff > 9'(MAX_GLYPHS)) eff_total = 9'(MAX_GLYPHS);
   end

   assign limit      = LIM_W'(eff_w) * LIM_W'(eff_h);
   assign pc_next    = {1'b0, pc_ff} + 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign map_we     = accept && (req_tuser == CMD_WRITE);
   assign emit_go    = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff     <= 32'd255;
         width_ff      <= 11'd1024;
         height_cfg_ff <= 9'd256;
         total_ff      <= 9'd256;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_MARKER: marker_ff     <= csr_wdata;
            REG_WIDTH:  width_ff      <= csr_wdata[10:0];
            REG_HEIGHT: height_cfg_ff <= csr_wdata[8:0];
            REG_TOTAL:  total_ff      <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rowh_new  = first_ff ? (yend_ff - ytop_ff) : rowh_ff;
      ytop_calc = $signed({2'b00, ytop_ff}) - $signed({2'b00, rowh_new}) + 11'sd1;
      rd_x      = x_ff;
      if (phase_ff == P_FIND_REF || phase_ff == P_REF_DOWN) rd_x = '0;
      else if (phase_ff == P_GLYPH_RIGHT) rd_x = xb_ff;
      gly_wr.rx   = x_ff + 1'b1;
      gly_wr.ry   = y_ff[YW-1:0] + 1'b1;
      gly_wr.rw   = {1'b0, xb_ff} - {1'b0, x_ff} - 12'd2;
      gly_wr.yoff = y_ff[YW-1:0] - yref_ff;
   end

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      pc_in          = pc_ff;
      found_in       = found_ff;
      rowh_in        = rowh_ff;
      refw_in        = refw_ff;
      first_in       = first_ff;
      x_in           = x_ff;
      xb_in          = xb_ff;
      y_in           = y_ff;
      yref_in        = yref_ff;
      ytop_in        = ytop_ff;
      yend_in        = yend_ff;
      pend_status_in = pend_status_ff;
      pend_rep_in    = pend_rep_ff;
      pend_rec_in    = pend_rec_ff;
      gly_we         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_tuser == CMD_WRITE) begin
                  if (pc_next >= limit) begin
                     pc_in    = '0;
                     found_in = '0;
                     rowh_in  = '0;
                     refw_in  = '0;
                     first_in = 1'b1;
                     y_in     = '0;
                     phase_in = P_FIND_REF;
                     state_in = S_STEP;
                  end else begin
                     pc_in = pc_next[MAP_AW-1:0];
                  end
               end else begin
                  pend_rep_in = 1'b0;
                  pend_rec_in = ({1'b0, gidx} < found_ff);
                  pend_status_in = ({1'b0, gidx} < found_ff) ? ST_OK : ST_BAD_INDEX;
                  state_in = S_EMIT;
               end
            end
         end
         S_STEP: begin
            pend_rep_in = 1'b1;
            pend_rec_in = 1'b0;
            unique case (phase_ff)
               P_FIND_REF: begin
                  if (y_ff >= {1'b0, eff_h}) begin
                     pend_status_in = ST_NO_REF;
                     state_in = S_EMIT;
                  end else state_in = S_ADDR;
               end
               P_REF_DOWN: begin
                  if (y_ff >= {1'b0, eff_h}) begin
                     pend_status_in = ST_UNTERM;
                     state_in = S_EMIT;
                  end else state_in = S_ADDR;
               end
               P_REF_RIGHT: begin
                  if (x_ff >= eff_w) begin
                     pend_status_in = ST_UNTERM;
                     state_in = S_EMIT;
                  end else state_in = S_ADDR;
               end
               P_COL_START: begin
                  if (x_ff < eff_w - 1'b1) begin
                     y_in     = {1'b0, ytop_ff};
                     phase_in = P_COL_SCAN;
                  end else if ({1'b0, y_ff} + {2'b00, rowh_ff} < {2'b00, eff_h}) begin
                     y_in     = {1'b0, yend_ff} + {2'b00, rowh_ff[YW-1:1]};
                     phase_in = P_FIND_REF;
                  end else begin
                     pend_status_in = ST_MISSING;
                     state_in = S_EMIT;
                  end
               end
               P_COL_SCAN: begin
                  if (y_ff < {1'b0, yend_ff}) state_in = S_ADDR;
                  else begin
                     x_in     = x_ff + 1'b1;
                     phase_in = P_COL_START;
                  end
               end
               P_GLYPH_RIGHT: begin
                  if (xb_ff >= eff_w) begin
                     pend_status_in = ST_UNTERM;
                     state_in = S_EMIT;
                  end else state_in = S_ADDR;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_ADDR: state_in = S_MEM;
         S_MEM:  state_in = S_EVAL;
         S_EVAL: begin
            state_in = S_STEP;
            unique case (phase_ff)
               P_FIND_REF: begin
                  if (map_q_ff) begin
                     yref_in  = y_ff[YW-1:0];
                     ytop_in  = y_ff[YW-1:0];
                     phase_in = P_REF_DOWN;
                  end
                  y_in = y_ff + 1'b1;
               end
               P_REF_DOWN: begin
                  if (map_q_ff) y_in = y_ff + 1'b1;
                  else begin
                     yend_in  = y_ff[YW-1:0];
                     y_in     = y_ff - 1'b1;
                     x_in     = 11'd1;
                     phase_in = P_REF_RIGHT;
                  end
               end
               P_REF_RIGHT: begin
                  if (map_q_ff) x_in = x_ff + 1'b1;
                  else begin
                     if (first_ff) begin
                        rowh_in  = rowh_new;
                        refw_in  = x_ff;
                        first_in = 1'b0;
                     end
                     ytop_in  = ytop_calc[YW+1] ? '0 : ytop_calc[YW-1:0];
                     x_in     = x_ff + 1'b1;
                     phase_in = P_COL_START;
                  end
               end
               P_COL_SCAN: begin
                  if (map_q_ff) begin
                     xb_in    = x_ff + 1'b1;
                     phase_in = P_GLYPH_RIGHT;
                  end else y_in = y_ff + 1'b1;
               end
               P_GLYPH_RIGHT: begin
                  if (map_q_ff) xb_in = xb_ff + 1'b1;
                  else begin
                     gly_we   = 1'b1;
                     found_in = found_ff + 1'b1;
                     if (found_ff + 1'b1 >= eff_total) begin
                        pend_status_in = ST_OK;
                        pend_rep_in    = 1'b1;
                        pend_rec_in    = 1'b0;
                        state_in       = S_EMIT;
                     end else begin
                        x_in     = xb_ff + 1'b1;
                        phase_in = P_COL_START;
                     end
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_EMIT: if (emit_go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         phase_ff    <= P_FIND_REF;
         pc_ff       <= '0;
         found_ff    <= '0;
         rowh_ff     <= '0;
         refw_ff     <= '0;
         first_ff    <= 1'b1;
         pend_rep_ff <= 1'b0;
         pend_rec_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         pc_ff       <= pc_in;
         found_ff    <= found_in;
         rowh_ff     <= rowh_in;
         refw_ff     <= refw_in;
         first_ff    <= first_in;
         pend_rep_ff <= pend_rep_in;
         pend_rec_ff <= pend_rec_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff           <= x_in;
      xb_ff          <= xb_in;
      y_ff           <= y_in;
      yref_ff        <= yref_in;
      ytop_ff        <= ytop_in;
      yend_ff        <= yend_in;
      pend_status_ff <= pend_status_in;
      if (state_ff == S_ADDR)
         addr_ff <= MAP_AW'(y_ff[YW-1:0]) * MAP_AW'(eff_w) + MAP_AW'(rd_x);
   end

   always_ff @(posedge clock) begin
      if (map_we) map_mem[pc_ff] <= (pixel == marker_ff);
      map_q_ff <= map_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (gly_we) gly_mem[found_ff[GLY_AW-1:0]] <= gly_wr;
      if (accept) gly_q_ff <= gly_mem[gidx[GLY_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (emit_go) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[2:0]   = pend_status_ff;
      rsp_data_in[11:3]  = found_ff;
      rsp_data_in[20:12] = rowh_ff;
      rsp_data_in[31:21] = refw_ff;
      if (pend_rec_ff) begin
         rsp_data_in[42:32] = gly_q_ff.rx;
         rsp_data_in[51:43] = gly_q_ff.ry;
         rsp_data_in[63:52] = gly_q_ff.rw;
         rsp_data_in[72:64] = rowh_ff - 9'd2;
         rsp_data_in[81:73] = gly_q_ff.yoff;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_user_ff <= pend_rep_ff;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_found_max: assert property (@(posedge clock) disable iff (reset)
      found_ff <= GW'(MAX_GLYPHS))
      else $error("glyph count overflow");

   a_map_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MEM) |-> ({1'b0, addr_ff} < limit))
      else $error("map read beyond sheet");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      emit_go |=> rsp_tvalid)
      else $error("result lost at emit");

   a_x_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && phase_ff != P_GLYPH_RIGHT) |-> (rd_x < eff_w))
      else $error("column beyond sheet");

endmodule
